[rtl/asm_pkg.sv]
// Shared types, constants and helpers of the arming state machine.
`default_nettype none
package asm_pkg;

  // Default width of one remote-control channel.
  localparam int unsigned ChannelBitsDef = 12;
  // Width at which the window bounds are written.
  localparam int unsigned BoundBits = 12;
  // Depth of the queues between the stages.
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned HoldBits  = 16;
  localparam int unsigned PulseBits = 12;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  // Reset values of the configuration registers.
  localparam logic [HoldBits-1:0]  ArmHoldRst     = 16'd200;
  localparam logic [HoldBits-1:0]  MagHoldRst     = 16'd200;
  localparam logic [PulseBits-1:0] LockedPulseRst = 12'd1000;
  localparam logic [PulseBits-1:0] IdlePulseRst   = 12'd1050;

  // Gesture and switch windows, exclusive on both ends.
  localparam logic [BoundBits-1:0] ArmStickLo = 12'd990;
  localparam logic [BoundBits-1:0] ArmStickHi = 12'd1050;
  localparam logic [BoundBits-1:0] ArmYawLo   = 12'd1950;
  localparam logic [BoundBits-1:0] ArmYawHi   = 12'd2010;
  localparam logic [BoundBits-1:0] MagStickLo = 12'd1950;
  localparam logic [BoundBits-1:0] MagStickHi = 12'd2050;
  localparam logic [BoundBits-1:0] MagYawLo   = 12'd950;
  localparam logic [BoundBits-1:0] MagYawHi   = 12'd1050;
  localparam logic [BoundBits-1:0] SwHighLo   = 12'd1400;
  localparam logic [BoundBits-1:0] SwHighHi   = 12'd2100;
  localparam logic [BoundBits-1:0] SwLowLo    = 12'd900;
  localparam logic [BoundBits-1:0] SwLowHi    = 12'd1100;

  typedef enum logic [CfgIdxBits-1:0] {
    RegArmHold    = 2'd0,
    RegMagHold    = 2'd1,
    RegLockedPuls = 2'd2,
    RegIdlePulse  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StLocked    = 4'b0001,
    StUnlocked  = 4'b0010,
    StFlying    = 4'b0100,
    StEmergency = 4'b1000
  } arm_state_e;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    logic link_up;
    logic remote_cal_active;
    logic mag_cal_busy;
    logic mag_gesture;
    logic arm_gesture;
    logic mode_fly;
    logic mode_unlock;
    logic kill;
  } tick_class_t;

  typedef struct packed {
    logic [1:0]           safe_state;
    logic [PulseBits-1:0] motor_pulse;
    logic                 mixer_active;
    logic                 mag_cal_trigger;
  } result_t;

  typedef struct packed {
    cfg_reg_e               index;
    logic [CfgDataBits-1:0] data;
  } cfg_wr_t;

  function automatic logic [1:0] state_code(arm_state_e s);
    logic [1:0] c;
    case (s)
      StLocked:    c = 2'd0;
      StUnlocked:  c = 2'd1;
      StFlying:    c = 2'd2;
      StEmergency: c = 2'd3;
      default:     c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [HoldBits-1:0] bump(logic [HoldBits-1:0] c);
    return (&c) ? c : c + HoldBits'(1);
  endfunction

endpackage
`default_nettype wire

[rtl/asm_fifo.sv]
// Small register queue between stages.
`default_nettype none
module asm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = asm_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PtrBits-1:0] nxt(logic [PtrBits-1:0] p);
    return (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= nxt(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= nxt(rptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/asm_front.sv]
// Front stage: classify each tick against the stick and switch windows.
`default_nettype none
module asm_front #(
  parameter int unsigned CHANNEL_BITS = asm_pkg::ChannelBitsDef
) (
  input  wire logic                    link_up_i,
  input  wire logic [CHANNEL_BITS-1:0] roll_stick_i,
  input  wire logic [CHANNEL_BITS-1:0] pitch_stick_i,
  input  wire logic [CHANNEL_BITS-1:0] throttle_stick_i,
  input  wire logic [CHANNEL_BITS-1:0] yaw_stick_i,
  input  wire logic [CHANNEL_BITS-1:0] mode_switch_i,
  input  wire logic [CHANNEL_BITS-1:0] kill_switch_i,
  input  wire logic                    remote_cal_active_i,
  input  wire logic                    mag_cal_busy_i,
  output asm_pkg::tick_class_t         class_o
);
  localparam int unsigned CmpW =
    (CHANNEL_BITS > asm_pkg::BoundBits) ? CHANNEL_BITS : asm_pkg::BoundBits;

  function automatic logic in_win(logic [CHANNEL_BITS-1:0] v,
                                  logic [asm_pkg::BoundBits-1:0] lo,
                                  logic [asm_pkg::BoundBits-1:0] hi);
    logic [CmpW-1:0] ve, le, he;
    ve = CmpW'(v);
    le = CmpW'(lo);
    he = CmpW'(hi);
    return (ve > le) && (ve < he);
  endfunction

  always_comb begin
    class_o.link_up           = link_up_i;
    class_o.remote_cal_active = remote_cal_active_i;
    class_o.mag_cal_busy      = mag_cal_busy_i;
    class_o.mag_gesture =
      in_win(roll_stick_i, asm_pkg::MagStickLo, asm_pkg::MagStickHi) &&
      in_win(pitch_stick_i, asm_pkg::MagStickLo, asm_pkg::MagStickHi) &&
      in_win(throttle_stick_i, asm_pkg::MagStickLo, asm_pkg::MagStickHi) &&
      in_win(yaw_stick_i, asm_pkg::MagYawLo, asm_pkg::MagYawHi);
    class_o.arm_gesture =
      in_win(roll_stick_i, asm_pkg::ArmStickLo, asm_pkg::ArmStickHi) &&
      in_win(pitch_stick_i, asm_pkg::ArmStickLo, asm_pkg::ArmStickHi) &&
      in_win(throttle_stick_i, asm_pkg::ArmStickLo, asm_pkg::ArmStickHi) &&
      in_win(yaw_stick_i, asm_pkg::ArmYawLo, asm_pkg::ArmYawHi);
    class_o.mode_fly    = in_win(mode_switch_i, asm_pkg::SwHighLo, asm_pkg::SwHighHi);
    class_o.mode_unlock = in_win(mode_switch_i, asm_pkg::SwLowLo, asm_pkg::SwLowHi);
    class_o.kill        = in_win(kill_switch_i, asm_pkg::SwHighLo, asm_pkg::SwHighHi);
  end
endmodule
`default_nettype wire

[rtl/asm_back.sv]
// Back stage: configuration registers, arming state and hold counters.
`default_nettype none
module asm_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire asm_pkg::cfg_wr_t     cfg_i,
  input  wire logic                 go_i,
  input  wire asm_pkg::tick_class_t class_i,
  output asm_pkg::result_t          result_o
);
  logic [asm_pkg::HoldBits-1:0]  arm_ticks_q, mag_ticks_q;
  logic [asm_pkg::PulseBits-1:0] locked_pulse_q, idle_pulse_q;
  asm_pkg::arm_state_e           state_q, state_d, st_sw;
  logic [asm_pkg::HoldBits-1:0]  arm_cnt_q, arm_cnt_d, mag_cnt_q, mag_cnt_d;
  logic [asm_pkg::HoldBits-1:0]  arm_inc, mag_inc;
  logic [asm_pkg::PulseBits-1:0] pulse;
  logic                          mixer, trig;

  always_comb begin
    state_d   = state_q;
    st_sw     = state_q;
    arm_cnt_d = arm_cnt_q;
    mag_cnt_d = mag_cnt_q;
    arm_inc   = asm_pkg::bump(arm_cnt_q);
    mag_inc   = asm_pkg::bump(mag_cnt_q);
    pulse     = locked_pulse_q;
    mixer     = 1'b0;
    trig      = 1'b0;
    if (!class_i.link_up) begin
      state_d = asm_pkg::StEmergency;
    end else begin
      case (state_q)
        asm_pkg::StUnlocked: pulse = idle_pulse_q;
        asm_pkg::StFlying: begin
          pulse = '0;
          mixer = 1'b1;
        end
        default: pulse = locked_pulse_q;
      endcase
      if (!class_i.remote_cal_active) begin
        // Magnetometer gesture
        if (!class_i.mag_cal_busy) begin
          if (class_i.mag_gesture) begin
            if (mag_inc > mag_ticks_q) begin
              trig      = 1'b1;
              mag_cnt_d = '0;
            end else begin
              mag_cnt_d = mag_inc;
            end
          end else begin
            mag_cnt_d = '0;
          end
        end
        // Mode and kill switches
        if (class_i.mode_fly && state_q == asm_pkg::StUnlocked) begin
          st_sw = asm_pkg::StFlying;
        end else if (class_i.mode_unlock && state_q == asm_pkg::StFlying) begin
          st_sw = asm_pkg::StUnlocked;
        end
        if (class_i.kill) begin
          st_sw = asm_pkg::StLocked;
        end
        state_d = st_sw;
        // Arm / disarm gesture
        if (class_i.arm_gesture) begin
          arm_cnt_d = arm_inc;
          if (arm_inc >= arm_ticks_q) begin
            if (st_sw == asm_pkg::StLocked) begin
              state_d   = asm_pkg::StUnlocked;
              arm_cnt_d = '0;
            end else if (st_sw == asm_pkg::StUnlocked) begin
              state_d   = asm_pkg::StLocked;
              arm_cnt_d = '0;
            end
          end
        end else begin
          arm_cnt_d = '0;
        end
      end
    end
    result_o.safe_state      = asm_pkg::state_code(state_d);
    result_o.motor_pulse     = pulse;
    result_o.mixer_active    = mixer;
    result_o.mag_cal_trigger = trig;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_ticks_q    <= asm_pkg::ArmHoldRst;
      mag_ticks_q    <= asm_pkg::MagHoldRst;
      locked_pulse_q <= asm_pkg::LockedPulseRst;
      idle_pulse_q   <= asm_pkg::IdlePulseRst;
    end else if (cfg_we_i) begin
      case (cfg_i.index)
        asm_pkg::RegArmHold:    arm_ticks_q    <= cfg_i.data;
        asm_pkg::RegMagHold:    mag_ticks_q    <= cfg_i.data;
        asm_pkg::RegLockedPuls: locked_pulse_q <= cfg_i.data[asm_pkg::PulseBits-1:0];
        asm_pkg::RegIdlePulse:  idle_pulse_q   <= cfg_i.data[asm_pkg::PulseBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= asm_pkg::StLocked;
      arm_cnt_q <= '0;
      mag_cnt_q <= '0;
    end else if (go_i) begin
      state_q   <= state_d;
      arm_cnt_q <= arm_cnt_d;
      mag_cnt_q <= mag_cnt_d;
    end
  end
endmodule
`default_nettype wire

[rtl/arming_state_machine_top.sv]
// Top level of the arming state machine: front, tick queue, back, result queue.
//
//  Channel   Handshake                   Carries
//  --------  --------------------------  ------------------------------------------
//  ticks in  push / full                 link, six channels, cal flags
//  results   empty / pop                 safe_state, motor_pulse, mixer, mag trigger
//  config    cfg_valid_i / cfg_ready_o   register index and write data
//
// An item is classified by the window compares as it is pushed and is registered in the
// tick queue; the back then updates state and counters and pushes the result into
// the result queue, from which it can be popped. One item per clock is sustained
// while the result side keeps popping. Reset clears both queues, the state (locked)
// and the counters, and loads register defaults. A stalled result side fills the
// result queue, then the tick queue, then raises full.
`default_nettype none
module arming_state_machine_top #(
  parameter int unsigned CHANNEL_BITS = asm_pkg::ChannelBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Tick input
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                link_up_i,
  input  wire logic [CHANNEL_BITS-1:0]             roll_stick_i,
  input  wire logic [CHANNEL_BITS-1:0]             pitch_stick_i,
  input  wire logic [CHANNEL_BITS-1:0]             throttle_stick_i,
  input  wire logic [CHANNEL_BITS-1:0]             yaw_stick_i,
  input  wire logic [CHANNEL_BITS-1:0]             mode_switch_i,
  input  wire logic [CHANNEL_BITS-1:0]             kill_switch_i,
  input  wire logic                                remote_cal_active_i,
  input  wire logic                                mag_cal_busy_i,
  // Results
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [1:0]                               safe_state_o,
  output logic [asm_pkg::PulseBits-1:0]            motor_pulse_o,
  output logic                                     mixer_active_o,
  output logic                                     mag_cal_trigger_o,
  // Configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [asm_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  wire logic [asm_pkg::CfgDataBits-1:0]     cfg_data_i
);
  localparam int unsigned ClassW  = $bits(asm_pkg::tick_class_t);
  localparam int unsigned ResultW = $bits(asm_pkg::result_t);

  asm_pkg::tick_class_t front_class, back_class;
  asm_pkg::result_t     back_result, out_result;
  asm_pkg::cfg_wr_t     cfg_wr;
  logic                 mid_empty, mid_full_unused, out_full, back_go;
  logic [ClassW-1:0]    mid_rdata;
  logic [ResultW-1:0]   out_rdata;

  // Registers may be written at any time; the user writes them only when idle.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.index = asm_pkg::cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  asm_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .link_up_i          (link_up_i),
    .roll_stick_i       (roll_stick_i),
    .pitch_stick_i      (pitch_stick_i),
    .throttle_stick_i   (throttle_stick_i),
    .yaw_stick_i        (yaw_stick_i),
    .mode_switch_i      (mode_switch_i),
    .kill_switch_i      (kill_switch_i),
    .remote_cal_active_i(remote_cal_active_i),
    .mag_cal_busy_i     (mag_cal_busy_i),
    .class_o            (front_class)
  );

  // Hold classified ticks until the back can take them.
  asm_fifo #(
    .Width(ClassW),
    .Depth(asm_pkg::QueueDepth)
  ) u_tick_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(front_class),
    .full_o (full),
    .pop_i  (back_go),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );
  assign mid_full_unused = full;
  assign back_class = asm_pkg::tick_class_t'(mid_rdata);

  // Advance the back only when a tick waits and the result queue has room.
  assign back_go = !mid_empty && !out_full;

  asm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_we_i(cfg_valid_i && cfg_ready_o),
    .cfg_i   (cfg_wr),
    .go_i    (back_go),
    .class_i (back_class),
    .result_o(back_result)
  );

  asm_fifo #(
    .Width(ResultW),
    .Depth(asm_pkg::QueueDepth)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_go),
    .wdata_i(back_result),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign out_result        = asm_pkg::result_t'(out_rdata);
  assign safe_state_o      = out_result.safe_state;
  assign motor_pulse_o     = out_result.motor_pulse;
  assign mixer_active_o    = out_result.mixer_active;
  assign mag_cal_trigger_o = out_result.mag_cal_trigger;

`ifndef SYNTH
  // The mixer owns the motors in flight: the fixed pulse must be zero.
  a_mixer_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mixer_active_o) |-> (motor_pulse_o == '0))
    else $error("mixer active with non-zero motor pulse");

  // A tick pushed into an idle block shows its result after passing the tick queue and the back.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && mid_empty && empty) |-> ##2 !empty)
    else $error("result missing two cycles after push into idle block");

  // The back never advances into a full result queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_go |-> (!out_full && !mid_empty && !mid_full_unused) || (full && !out_full))
    else $error("back stage advanced while blocked");
`endif
endmodule
`default_nettype wire
